/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge while reset is low.
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/jd2g_pkg.sv */
// ----------------------------------------------------------------------------
// jd2g_pkg
// Constants, types and the month table for the Julian Date converter.
// ----------------------------------------------------------------------------
`default_nettype none

package jd2g_pkg;

   // Field widths
   localparam int JD_W      = 54;
   localparam int YEAR_W    = 14;
   localparam int MONTH_W   = 4;
   localparam int DAY_W     = 6;
   localparam int HOUR_W    = 5;
   localparam int MINUTE_W  = 6;
   localparam int SECOND_W  = 6;

   // Quotient bits retired per stage of a constant divider
   localparam int DIGIT_BITS = 3;

   // Gregorian correction
   localparam int GREG_START = 2299161;
   localparam int GREG_W     = $clog2(GREG_START);
   localparam int ALPHA_OFS  = 7468865;
   localparam int GREG_CYCLE = 146097;

   // Day number to year and day of year
   localparam int ADJ_DAYS  = 1524;
   localparam int C_SCALE   = 20;
   localparam int C_NUM_OFS = 2442;
   localparam int C_DEN     = 7305;
   localparam int D_MUL     = 1461;

   // Day of year to month, 30.6001 as a ratio
   localparam int E_NUM = 306001;
   localparam int E_DEN = 10000;
   localparam int E_W   = 4;
   localparam int E_MAX = 15;
   localparam int BD_W  = 9;

   // Month and year fix-up
   localparam int E_WRAP         = 14;
   localparam int MONTH_OFS_LOW  = 1;
   localparam int MONTH_OFS_HIGH = 13;
   localparam int LAST_EARLY_MON = 2;
   localparam int YEAR_OFS_LATE  = 4716;
   localparam int YEAR_OFS_EARLY = 4715;

   // Time of day
   localparam int SEC_PER_DAY   = 86400;
   localparam int SEC_PER_MIN   = 60;
   localparam int MIN_PER_HOUR  = 60;
   localparam int TSEC_W        = $clog2(SEC_PER_DAY + 1);
   localparam int MIN_DAY_W     = $clog2(SEC_PER_DAY / SEC_PER_MIN);

   typedef struct packed {
      logic [E_W-1:0]  e;
      logic [BD_W-1:0] ed;
   } month_split_type;

   typedef struct packed {
      logic [TSEC_W-1:0] tsec;
      logic              wrap;
   } tod_type;

   typedef struct packed {
      logic signed [YEAR_W-1:0] year;
      logic [MONTH_W-1:0]       month;
      logic [DAY_W-1:0]         day;
   } date_type;

   // e = floor(bd / 30.6001) and ed = floor(30.6001 * e), by threshold compares
   function automatic month_split_type meeus_month_split(input logic [BD_W-1:0] bd);
      month_split_type res;
      res.e  = '0;
      res.ed = '0;
      for (int k = 1; k <= E_MAX; k++) begin
         if (bd >= BD_W'((E_NUM * k + E_DEN - 1) / E_DEN)) begin
            res.e  = E_W'(k);
            res.ed = BD_W'((E_NUM * k) / E_DEN);
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

/* rtl/jd2g_cdiv.sv */
// ----------------------------------------------------------------------------
// jd2g_cdiv
// Pipelined divider by a constant: DIGIT_BITS quotient bits per stage, chosen
// by parallel compares against the divisor's multiples. A tag rides along.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module jd2g_cdiv
   import jd2g_pkg::*;
#(
   parameter int N_W     = 29,
   parameter int DIVISOR = 7305,
   parameter int TAG_W   = 8,
   parameter int R_W     = $clog2(DIVISOR)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [N_W-1:0]   in_num,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [N_W-1:0]   out_quo,
   output logic [R_W-1:0]   out_rem,
   output logic [TAG_W-1:0] out_tag
);

   localparam int NSTG   = (N_W + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int PAD_W  = NSTG * DIGIT_BITS;
   localparam int X_W    = R_W + DIGIT_BITS;
   localparam int DIGITS = 2 ** DIGIT_BITS;

   logic             vld_ff   [NSTG];
   logic [R_W-1:0]   rem_ff   [NSTG];
   logic [PAD_W-1:0] work_ff  [NSTG];
   logic [TAG_W-1:0] tag_ff   [NSTG];

   logic             vld_in   [NSTG];
   logic [TAG_W-1:0] tag_in   [NSTG];
   logic [R_W-1:0]   rem_in   [NSTG];
   logic [PAD_W-1:0] work_in  [NSTG];
   logic [R_W-1:0]   src_rem  [NSTG];
   logic [PAD_W-1:0] src_work [NSTG];

   for (genvar i = 0; i < NSTG; i++) begin : g_stage
      // stage source: the request for the first stage, the previous stage otherwise
      if (i == 0) begin : g_first
         assign vld_in[i]   = in_valid;
         assign tag_in[i]   = in_tag;
         assign src_rem[i]  = '0;
         assign src_work[i] = PAD_W'(in_num);
      end else begin : g_next
         assign vld_in[i]   = vld_ff[i-1];
         assign tag_in[i]   = tag_ff[i-1];
         assign src_rem[i]  = rem_ff[i-1];
         assign src_work[i] = work_ff[i-1];
      end

      // one quotient digit: largest multiple not above the partial remainder
      always_comb begin
         logic [X_W-1:0]        x;
         logic [X_W-1:0]        sub;
         logic [DIGIT_BITS-1:0] dig;
         x   = {src_rem[i], src_work[i][PAD_W-1 -: DIGIT_BITS]};
         sub = '0;
         dig = '0;
         for (int k = 1; k < DIGITS; k++) begin
            if (x >= X_W'(DIVISOR) * X_W'(k)) begin
               dig = DIGIT_BITS'(k);
               sub = X_W'(DIVISOR) * X_W'(k);
            end
         end
         rem_in[i]  = R_W'(x - sub);
         work_in[i] = {src_work[i][PAD_W-DIGIT_BITS-1:0], dig};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_in[i];
         end
         rem_ff[i]  <= rem_in[i];
         work_ff[i] <= work_in[i];
         tag_ff[i]  <= tag_in[i];
      end
   end

   assign out_valid = vld_ff[NSTG-1];
   assign out_quo   = work_ff[NSTG-1][N_W-1:0];
   assign out_rem   = rem_ff[NSTG-1];
   assign out_tag   = tag_ff[NSTG-1];

   `ASSERT_RST(a_rem_bound, clock, reset, out_valid |-> (int'(out_rem) < DIVISOR), "remainder not below divisor")
   `ASSERT_RST(a_latency, clock, reset, out_valid |-> $past(in_valid, NSTG), "result without matching request")

endmodule

`default_nettype wire

/* rtl/julian_date_to_gregorian.sv */
// ----------------------------------------------------------------------------
// julian_date_to_gregorian
// Julian Date in fixed point to calendar date and rounded time of day.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low. busy is
//   low except while reset is held, so a request may be issued every cycle.
//   Each request yields one result, shown for one cycle with rsp_valid high;
//   results leave in request order. The receiver cannot stall the block.
// Pipeline:
//   The date path holds two dividers by 146097 and 7305, each retiring 3
//   quotient bits per stage over DW = max(55 - FRACTION_BITS, 22) + 6 bits.
// Throughput:
//   One request per cycle; every stage is a register and nothing iterates.
// Reset:
//   Synchronous, active high. All valid bits clear, so requests in flight are
//   dropped and no result appears in the cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module julian_date_to_gregorian
   import jd2g_pkg::*;
#(
   parameter int FRACTION_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [JD_W-1:0]            req_julian_date_fixed,
   output logic                       rsp_valid,
   output logic signed [YEAR_W-1:0]   rsp_year,
   output logic [MONTH_W-1:0]         rsp_month,
   output logic [DAY_W-1:0]           rsp_day,
   output logic [HOUR_W-1:0]          rsp_hour,
   output logic [MINUTE_W-1:0]        rsp_minute,
   output logic [SECOND_W-1:0]        rsp_second
);

   localparam int FB     = FRACTION_BITS;
   localparam int SUM_W  = JD_W + 1;
   localparam int JN_W   = SUM_W - FB;
   localparam int W0     = (JN_W > GREG_W) ? JN_W : GREG_W;
   localparam int DW     = W0 + 6;
   localparam int PROD_W = FB + TSEC_W;

   typedef struct packed {
      logic [DW-1:0] jn;
      logic          greg;
      tod_type       tod;
   } alpha_tag_type;

   typedef struct packed {
      logic [DW-1:0] b;
      tod_type       tod;
   } cent_tag_type;

   typedef struct packed {
      date_type              date;
      logic [SECOND_W-1:0]   second;
   } hour_tag_type;

   // input register
   logic            v0_ff, v0_in;
   logic [JD_W-1:0] jdf0_ff;

   assign busy  = reset;
   assign v0_in = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
      end
      jdf0_ff <= req_julian_date_fixed;
   end

   // P1: add half a day, split into day number and fraction
   logic [SUM_W-1:0] sum1;
   logic             v1_ff;
   logic [DW-1:0]    jn1_ff, jn1_in;
   logic [FB-1:0]    frac1_ff, frac1_in;

   always_comb begin
      sum1     = {1'b0, jdf0_ff} + (SUM_W'(1) << (FB - 1));
      jn1_in   = DW'(sum1[SUM_W-1:FB]);
      frac1_in = sum1[FB-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
      jn1_ff   <= jn1_in;
      frac1_ff <= frac1_in;
   end

   // P2: reform test, century dividend, scaled fraction of day
   logic              v2_ff;
   logic [DW-1:0]     jn2_ff;
   logic              greg2_ff, greg2_in;
   logic [DW-1:0]     num1_ff, num1_in;
   logic [PROD_W-1:0] prod2_ff, prod2_in;

   always_comb begin
      greg2_in = jn1_ff >= DW'(GREG_START);
      num1_in  = greg2_in ? (jn1_ff << 2) - DW'(ALPHA_OFS) : '0;
      prod2_in = PROD_W'(frac1_ff) * PROD_W'(SEC_PER_DAY) + (PROD_W'(1) << (FB - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      jn2_ff   <= jn1_ff;
      greg2_ff <= greg2_in;
      num1_ff  <= num1_in;
      prod2_ff <= prod2_in;
   end

   // rounded seconds of day; a full day wraps to midnight
   logic [TSEC_W-1:0] tsec_raw;
   alpha_tag_type     atag_in, atag_out;
   logic              v_alpha;
   logic [DW-1:0]     alpha_q;
   logic [$clog2(GREG_CYCLE)-1:0] alpha_r;

   always_comb begin
      tsec_raw          = prod2_ff[PROD_W-1:FB];
      atag_in.jn        = jn2_ff;
      atag_in.greg      = greg2_ff;
      atag_in.tod.wrap  = tsec_raw >= TSEC_W'(SEC_PER_DAY);
      atag_in.tod.tsec  = atag_in.tod.wrap ? '0 : tsec_raw;
   end

   jd2g_cdiv #(
      .N_W     (DW),
      .DIVISOR (GREG_CYCLE),
      .TAG_W   ($bits(alpha_tag_type))
   ) u_div_alpha (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .in_num    (num1_ff),
      .in_tag    (atag_in),
      .out_valid (v_alpha),
      .out_quo   (alpha_q),
      .out_rem   (alpha_r),
      .out_tag   (atag_out)
   );

   // P3: Gregorian correction and day offset
   logic          v3_ff;
   logic [DW-1:0] b3_ff, b3_in;
   tod_type       tod3_ff;

   always_comb begin
      if (atag_out.greg) begin
         b3_in = atag_out.jn + alpha_q - (alpha_q >> 2) + DW'(ADJ_DAYS + 1);
      end else begin
         b3_in = atag_out.jn + DW'(ADJ_DAYS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v_alpha;
      end
      b3_ff   <= b3_in;
      tod3_ff <= atag_out.tod;
   end

   // P4: year dividend
   logic          v4_ff;
   logic [DW-1:0] num2_ff, num2_in;
   cent_tag_type  ctag4_ff;

   assign num2_in = b3_ff * DW'(C_SCALE) - DW'(C_NUM_OFS);

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      num2_ff      <= num2_in;
      ctag4_ff.b   <= b3_ff;
      ctag4_ff.tod <= tod3_ff;
   end

   cent_tag_type              ctag_out;
   logic                      v_year;
   logic [DW-1:0]             c_q;
   logic [$clog2(C_DEN)-1:0]  c_r;

   jd2g_cdiv #(
      .N_W     (DW),
      .DIVISOR (C_DEN),
      .TAG_W   ($bits(cent_tag_type))
   ) u_div_year (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_num    (num2_ff),
      .in_tag    (ctag4_ff),
      .out_valid (v_year),
      .out_quo   (c_q),
      .out_rem   (c_r),
      .out_tag   (ctag_out)
   );

   // P5: day of year (always 123..488, so it fits in BD_W bits)
   logic              v5_ff;
   logic [DW-1:0]     d5;
   logic [BD_W-1:0]   bd5_ff, bd5_in;
   logic [YEAR_W-1:0] c5_ff;
   tod_type           tod5_ff;

   always_comb begin
      d5     = (c_q * DW'(D_MUL)) >> 2;
      bd5_in = BD_W'(ctag_out.b - d5);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v_year;
      end
      bd5_ff  <= bd5_in;
      c5_ff   <= c_q[YEAR_W-1:0];
      tod5_ff <= ctag_out.tod;
   end

   // P6: month, day and year; midnight carry bumps the day with no month check
   logic              v6_ff;
   month_split_type   split6;
   logic [BD_W-1:0]   dom6;
   date_type          date6_ff, date6_in;
   logic [TSEC_W-1:0] tsec6_ff;

   always_comb begin
      split6         = meeus_month_split(bd5_ff);
      dom6           = bd5_ff - split6.ed;
      date6_in.day   = DAY_W'(dom6) + DAY_W'(tod5_ff.wrap);
      date6_in.month = (split6.e < E_W'(E_WRAP)) ? MONTH_W'(split6.e - E_W'(MONTH_OFS_LOW))
                                                 : MONTH_W'(split6.e - E_W'(MONTH_OFS_HIGH));
      if (date6_in.month > MONTH_W'(LAST_EARLY_MON)) begin
         date6_in.year = signed'(c5_ff - YEAR_W'(YEAR_OFS_LATE));
      end else begin
         date6_in.year = signed'(c5_ff - YEAR_W'(YEAR_OFS_EARLY));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
      date6_ff <= date6_in;
      tsec6_ff <= tod5_ff.tsec;
   end

   // seconds of day to minutes of day and second
   date_type            mtag_out;
   logic                v_min;
   logic [TSEC_W-1:0]   min_q;
   logic [SECOND_W-1:0] sec_r;
   hour_tag_type        htag_in, htag_out;

   jd2g_cdiv #(
      .N_W     (TSEC_W),
      .DIVISOR (SEC_PER_MIN),
      .TAG_W   ($bits(date_type))
   ) u_div_min (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v6_ff),
      .in_num    (tsec6_ff),
      .in_tag    (date6_ff),
      .out_valid (v_min),
      .out_quo   (min_q),
      .out_rem   (sec_r),
      .out_tag   (mtag_out)
   );

   // minutes of day to hour and minute
   logic                 v_hour;
   logic [MIN_DAY_W-1:0] hour_q;
   logic [MINUTE_W-1:0]  min_r;

   always_comb begin
      htag_in.date   = mtag_out;
      htag_in.second = sec_r;
   end

   jd2g_cdiv #(
      .N_W     (MIN_DAY_W),
      .DIVISOR (MIN_PER_HOUR),
      .TAG_W   ($bits(hour_tag_type))
   ) u_div_hour (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v_min),
      .in_num    (min_q[MIN_DAY_W-1:0]),
      .in_tag    (htag_in),
      .out_valid (v_hour),
      .out_quo   (hour_q),
      .out_rem   (min_r),
      .out_tag   (htag_out)
   );

   // result ports straight from the last divider's registers
   assign rsp_valid  = v_hour;
   assign rsp_year   = htag_out.date.year;
   assign rsp_month  = htag_out.date.month;
   assign rsp_day    = htag_out.date.day;
   assign rsp_hour   = hour_q[HOUR_W-1:0];
   assign rsp_minute = min_r;
   assign rsp_second = htag_out.second;

   `ASSERT_RST(a_month_range, clock, reset, rsp_valid |-> (rsp_month >= MONTH_W'(1) && rsp_month <= MONTH_W'(12)), "month out of range")
   `ASSERT_RST(a_day_range, clock, reset, rsp_valid |-> (rsp_day >= DAY_W'(1) && rsp_day <= DAY_W'(32)), "day out of range")
   `ASSERT_RST(a_time_range, clock, reset, rsp_valid |-> (rsp_hour < HOUR_W'(24) && rsp_minute < MINUTE_W'(60) && rsp_second < SECOND_W'(60)), "time of day out of range")
   `ASSERT_ALWAYS(a_reset_flush, clock, reset |=> !rsp_valid, "result right after reset")

endmodule

`default_nettype wire

/* bench/julian_date_to_gregorian_tb.sv */
// ----------------------------------------------------------------------------
// julian_date_to_gregorian_tb
// Self-checking bench for the Julian Date to calendar converter.
// A directed set covers the ends of the input range, both sides of the
// calendar reform day, rounding ties and the naive midnight rollover. A long
// random run with sender gaps follows. Every accepted request is converted by
// an integer model of Meeus' method, and the expected date and time are then
// matched in order against the strobed results.
// ----------------------------------------------------------------------------

module julian_date_to_gregorian_tb
   import jd2g_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS       = 32;
   localparam int RESET_CYCLES    = 11;
   localparam int RANDOM_REQUESTS = 730;
   localparam int STEADY_TAIL     = 120;
   localparam int DRAIN_CYCLES    = 64;
   localparam int WATCHDOG_LIMIT  = 1000;

   localparam longint unsigned HALF_DAY   = 64'd1 << (FRAC_BITS - 1);
   localparam longint unsigned FULL_DAY   = 64'd1 << FRAC_BITS;
   localparam longint unsigned REFORM_DAY = 64'd2299161;
   localparam longint unsigned DAY_SECS   = 64'd86400;
   localparam longint unsigned MAX_DAYNUM = 64'd4194303;

   typedef struct packed {
      logic signed [YEAR_W-1:0] year;
      logic [MONTH_W-1:0]       month;
      logic [DAY_W-1:0]         day;
      logic [HOUR_W-1:0]        hour;
      logic [MINUTE_W-1:0]      minute;
      logic [SECOND_W-1:0]      second;
   } calendar_type;

   typedef struct {
      logic [JD_W-1:0] jd;
      calendar_type    cal;
   } pending_type;

   // Expected calendar results, in request order
   class calendar_scoreboard;
      pending_type pending_q[$];
      int unsigned requests;
      int unsigned checked;
      int unsigned julian_days;
      int unsigned midnight_carries;
      int unsigned mismatches;

      // Meeus' conversion in exact integer arithmetic
      function calendar_type convert_jd(input logic [JD_W-1:0] jd, output bit julian,
                                        output bit carried);
         calendar_type    res;
         longint unsigned shifted, day_num, day_frac, alpha, a, b, c, d, e;
         longint unsigned dom, mon, tsec;
         longint          yr;
         shifted  = 64'(jd) + HALF_DAY;
         day_num  = shifted >> FRAC_BITS;
         day_frac = shifted & (FULL_DAY - 1);
         julian   = (day_num < REFORM_DAY);
         if (!julian) begin
            alpha = (4 * day_num - 64'd7468865) / 64'd146097;
            a     = day_num + 1 + alpha - alpha / 4;
         end else begin
            a = day_num;
         end
         b   = a + 64'd1524;
         c   = (20 * b - 64'd2442) / 64'd7305;
         d   = (64'd1461 * c) / 4;
         e   = (64'd10000 * (b - d)) / 64'd306001;
         dom = b - d - (64'd306001 * e) / 64'd10000;
         mon = (e < 14) ? e - 1 : e - 13;
         yr  = (mon > 2) ? longint'(c) - 4716 : longint'(c) - 4715;
         // time of day, nearest second with ties up
         tsec    = (day_frac * DAY_SECS + HALF_DAY) >> FRAC_BITS;
         carried = (tsec >= DAY_SECS);
         if (carried) begin
            tsec = 0;
            dom  = dom + 1;
         end
         res.year   = YEAR_W'(yr);
         res.month  = MONTH_W'(mon);
         res.day    = DAY_W'(dom);
         res.hour   = HOUR_W'(tsec / 3600);
         res.minute = MINUTE_W'((tsec % 3600) / 60);
         res.second = SECOND_W'(tsec % 60);
         return res;
      endfunction

      function void note_request(input logic [JD_W-1:0] jd);
         pending_type entry;
         bit          julian, carried;
         entry.jd  = jd;
         entry.cal = convert_jd(jd, julian, carried);
         pending_q.push_back(entry);
         requests++;
         julian_days      += julian;
         midnight_carries += carried;
      endfunction

      task report_mismatch(input string msg);
         $display("[%0t] MISMATCH: %s", $realtime, msg);
         mismatches++;
      endtask

      task compare_field(input string name, input logic [JD_W-1:0] jd,
                         input logic signed [31:0] got, input logic signed [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("jd 0x%h %s got %0d expected %0d",
                                      jd, name, got, want));
      endtask

      task check_result(input calendar_type got);
         pending_type want;
         if (pending_q.size() == 0) begin
            report_mismatch($sformatf("result %0d-%0d-%0d %0d:%0d:%0d with no request open",
                                      got.year, got.month, got.day,
                                      got.hour, got.minute, got.second));
            return;
         end
         want = pending_q.pop_front();
         checked++;
         compare_field("year", want.jd, got.year, want.cal.year);
         compare_field("month", want.jd, got.month, want.cal.month);
         compare_field("day", want.jd, got.day, want.cal.day);
         compare_field("hour", want.jd, got.hour, want.cal.hour);
         compare_field("minute", want.jd, got.minute, want.cal.minute);
         compare_field("second", want.jd, got.second, want.cal.second);
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic [JD_W-1:0]          req_julian_date_fixed = '0;
   logic                     busy;
   logic                     rsp_valid;
   logic signed [YEAR_W-1:0] rsp_year;
   logic [MONTH_W-1:0]       rsp_month;
   logic [DAY_W-1:0]         rsp_day;
   logic [HOUR_W-1:0]        rsp_hour;
   logic [MINUTE_W-1:0]      rsp_minute;
   logic [SECOND_W-1:0]      rsp_second;

   calendar_scoreboard sb;
   int unsigned        quiet_cycles = 0;

   julian_date_to_gregorian #(
      .FRACTION_BITS(FRAC_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_julian_date_fixed(req_julian_date_fixed),
      .rsp_valid(rsp_valid),
      .rsp_year(rsp_year),
      .rsp_month(rsp_month),
      .rsp_day(rsp_day),
      .rsp_hour(rsp_hour),
      .rsp_minute(rsp_minute),
      .rsp_second(rsp_second)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Request acceptance and result check, both on pre-edge values
   always @(posedge clock) begin
      if (!reset && start && !busy)
         sb.note_request(req_julian_date_fixed);
      if (!reset && rsp_valid)
         sb.check_result({rsp_year, rsp_month, rsp_day, rsp_hour, rsp_minute, rsp_second});
   end

   // Watchdog: too long with neither a request nor a result accepted
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Input value whose day number (after the half-day shift) and fraction are given
   function automatic logic [JD_W-1:0] jd_at(input longint unsigned day_num,
                                             input longint unsigned frac);
      return JD_W'((day_num << FRAC_BITS) + frac - HALF_DAY);
   endfunction

   // Random request: raw bits, reform edge, near midnight, ties, any day
   function automatic logic [JD_W-1:0] random_jd();
      logic [63:0]     raw;
      longint unsigned frac;
      raw  = {$urandom, $urandom};
      frac = 64'($urandom);
      case ($urandom_range(0, 9))
         0, 1, 2: return raw[JD_W-1:0];
         3:       return jd_at(REFORM_DAY - 40 + $urandom_range(0, 80), frac);
         4:       return jd_at($urandom_range(2400000, 2500000),
                               FULL_DAY - $urandom_range(1, 60000));
         5:       return jd_at($urandom_range(0, MAX_DAYNUM),
                               64'(2 * $urandom_range(0, 255) + 1) << 24);
         default: return jd_at($urandom_range(0, MAX_DAYNUM), frac);
      endcase
   endfunction

   task automatic send_request(input logic [JD_W-1:0] jd);
      start                 <= 1'b1;
      req_julian_date_fixed <= jd;
      do @(posedge clock); while (busy);
   endtask

   // Sender gap now and then, when allowed
   task automatic pause_sender(input bit allowed);
      if (allowed && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   initial begin
      logic [JD_W-1:0] directed_q[$];
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: range ends, reform day, leap day, ties, midnight rollover
      directed_q = '{
         '0, '1, 54'h2AAAAAAAAAAAAA, 54'h15555555555555,
         jd_at(REFORM_DAY - 1, 0), jd_at(REFORM_DAY, 0),
         jd_at(REFORM_DAY - 1, FULL_DAY - 1),
         jd_at(2451575, FULL_DAY - 1),
         jd_at(2451604, 0), jd_at(2451605, 0),
         jd_at(2451545, 64'd1 << 24), jd_at(2451545, (64'd1 << 24) - 1),
         jd_at(2451545, HALF_DAY),
         jd_at(2451545, FULL_DAY - 24856), jd_at(2451545, FULL_DAY - 24855),
         jd_at(0, FULL_DAY - 1),
         jd_at(2451969, FULL_DAY - 1), jd_at(2451910, FULL_DAY - 1),
         jd_at(MAX_DAYNUM, 0)
      };
      foreach (directed_q[i]) begin
         send_request(directed_q[i]);
         pause_sender(1'b1);
      end

      // Random part; no sender gaps over the last stretch
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         send_request(random_jd());
         pause_sender(n < RANDOM_REQUESTS - STEADY_TAIL);
      end
      start <= 1'b0;

      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending_q.size() != 0)
         sb.report_mismatch("requests left without a result");

      $display("Converted %0d dates: %0d in the Julian calendar, %0d rounded to midnight",
               sb.requests, sb.julian_days, sb.midnight_carries);
      $display("Checked %0d results, %0d mismatches", sb.checked, sb.mismatches);
      if (sb.mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/jd2g_pkg.sv
rtl/jd2g_cdiv.sv
rtl/julian_date_to_gregorian.sv
bench/julian_date_to_gregorian_tb.sv
